[rtl/serial_setpoint_command_parser_macros.svh]
// Assertion macros for the serial setpoint command parser
`ifndef SERIAL_SETPOINT_COMMAND_PARSER_MACROS_SVH
`define SERIAL_SETPOINT_COMMAND_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SSPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sspc assertion failed");

// Next-cycle implication, disabled during reset
`define SSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sspc assertion failed");

`endif

[rtl/sspc_pkg.sv]
package sspc_pkg;

  localparam int unsigned MaxChars = 12;
  localparam int unsigned CountW   = 4;
  localparam int unsigned ValueW   = 32;

  localparam logic [7:0] ChArm1  = 8'h70;
  localparam logic [7:0] ChArm2  = 8'h71;
  localparam logic [7:0] ChRotor = 8'h72;
  localparam logic [7:0] ChDist  = 8'h64;
  localparam logic [7:0] ChOn    = 8'h6F;
  localparam logic [7:0] ChOff   = 8'h66;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [ValueW-1:0] DigitBase = 32'd48;

  typedef enum logic [2:0] {
    TgtNone  = 3'd0,
    TgtArm1  = 3'd1,
    TgtArm2  = 3'd2,
    TgtRotor = 3'd3,
    TgtDist  = 3'd4
  } target_e;

  typedef struct packed {
    target_e                  update_target;
    logic signed [ValueW-1:0] value;
    logic                     nozzle_open;
    logic                     recalibrate;
    logic                     dropped;
  } sspc_res_t;

endpackage

[rtl/sspc_core.sv]
module sspc_core import sspc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] rx_byte_i,
  output sspc_res_t  res_o
);

  logic [ValueW-1:0] sum_q, sum_d;
  logic              neg_q, neg_d;
  logic [CountW-1:0] count_q, count_d;
  logic              nozzle_q, nozzle_d;

  logic [ValueW-1:0] sum_x10;
  logic [ValueW-1:0] digit;
  logic              full;

  assign sum_x10 = (sum_q << 3) + (sum_q << 1);
  assign digit   = {{(ValueW-8){1'b0}}, rx_byte_i} - DigitBase;
  assign full    = (count_q >= CountW'(MaxChars));

  always_comb begin
    sum_d    = sum_q;
    neg_d    = neg_q;
    count_d  = count_q;
    nozzle_d = nozzle_q;
    res_o    = '0;
    res_o.update_target = TgtNone;

    unique case (rx_byte_i)
      ChArm1, ChArm2, ChRotor, ChDist: begin
        unique case (rx_byte_i)
          ChArm1:  res_o.update_target = TgtArm1;
          ChArm2:  res_o.update_target = TgtArm2;
          ChRotor: res_o.update_target = TgtRotor;
          default: res_o.update_target = TgtDist;
        endcase
        res_o.value       = neg_q ? -$signed(sum_q) : $signed(sum_q);
        res_o.recalibrate = (rx_byte_i != ChRotor);
        sum_d   = '0;
        neg_d   = 1'b0;
        count_d = '0;
      end
      ChOn:  nozzle_d = 1'b1;
      ChOff: nozzle_d = 1'b0;
      default: begin
        if (full) begin
          res_o.dropped = 1'b1;
        end else begin
          if (count_q == '0 && rx_byte_i == ChMinus) begin
            neg_d = 1'b1;
          end else begin
            if (count_q == '0) begin
              neg_d = 1'b0;
            end
            sum_d = sum_x10 + digit;
          end
          count_d = count_q + CountW'(1);
        end
      end
    endcase

    res_o.nozzle_open = nozzle_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      neg_q    <= 1'b0;
      count_q  <= '0;
      nozzle_q <= 1'b0;
    end else if (take_i) begin
      sum_q    <= sum_d;
      neg_q    <= neg_d;
      count_q  <= count_d;
      nozzle_q <= nozzle_d;
    end
  end

endmodule

[rtl/serial_setpoint_command_parser.sv]
// Serial setpoint command parser: takes one received byte per transfer and
// returns exactly one result per byte. The letters p, q, r and d commit the
// buffered signed number to arm one, arm two, the rotor or the distance and
// clear the buffer (p, q and d also pulse recalibrate); o and f switch the
// nozzle; any other byte is buffered, with a leading '-' as sign, up to
// twelve characters, after which it is dropped and flagged. Each byte passes
// through a shift-add multiply-by-ten stage into the result register; a new
// byte is taken every cycle while the result register is empty or being
// drained in the same cycle.
module serial_setpoint_command_parser import sspc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         update_target_o,
  output logic signed [31:0] value_o,
  output logic               nozzle_open_o,
  output logic               recalibrate_o,
  output logic               dropped_o
);

  `include "serial_setpoint_command_parser_macros.svh"

  logic      take;
  logic      valid_q;
  sspc_res_t res_d, res_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  sspc_core u_core (
    .clk_i,
    .rst_ni,
    .take_i    (take),
    .rx_byte_i,
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign update_target_o = res_q.update_target;
  assign value_o         = res_q.value;
  assign nozzle_open_o   = res_q.nozzle_open;
  assign recalibrate_o   = res_q.recalibrate;
  assign dropped_o       = res_q.dropped;

  `SSPC_ASSERT_NEXT(a_take_fills, clk_i, rst_ni, take, out_valid_o)
  `SSPC_ASSERT_NOW(a_idle_value_zero, clk_i, rst_ni,
                   out_valid_o && update_target_o == TgtNone, value_o == '0)
  `SSPC_ASSERT_NOW(a_recal_commit, clk_i, rst_ni, out_valid_o && recalibrate_o,
                   update_target_o == TgtArm1 || update_target_o == TgtArm2 ||
                   update_target_o == TgtDist)
  `SSPC_ASSERT_NOW(a_drop_no_commit, clk_i, rst_ni, out_valid_o && dropped_o,
                   update_target_o == TgtNone && !recalibrate_o)

endmodule
